[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[sv/ntps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest track point search package
// Field widths, item codes, state encoding and shared types.
// ----------------------------------------------------------------------------
package ntps_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W;
  localparam int STAMP_W  = KEY_W + SEC_W;
  localparam int DIST_W   = SEC_W + 1;
  localparam int IDX_OUT_W = 10;

  localparam logic [DIST_W-1:0] MINUTE_SECONDS = DIST_W'(60);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  typedef struct packed {
    logic accept;    // item taken this cycle
    logic scan;      // walk the table
    logic load_out;  // capture result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;      // search finished
  } dp_status_t;

  function automatic logic [DIST_W-1:0] abs_diff(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[sv/ntps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest track point search controller
// Sequences accept, table walk and result hand-off, one item at a time.
// ----------------------------------------------------------------------------
module ntps_ctrl
  import ntps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (mode_i == MODE_QUERY) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/ntps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest track point search datapath
// Stamp memory, point count, streaming match and nearest-second selection.
// ----------------------------------------------------------------------------
module ntps_datapath
  import ntps_pkg::*;
#(
  parameter int POINTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic [1:0]           mode_i,
  input  logic [YEAR_W-1:0]    year_i,
  input  logic [MONTH_W-1:0]   month_i,
  input  logic [DAY_W-1:0]     day_i,
  input  logic [HOUR_W-1:0]    hour_i,
  input  logic [MIN_W-1:0]     minute_i,
  input  logic [SEC_W-1:0]     second_i,
  output logic                 found_o,
  output logic [IDX_OUT_W-1:0] point_index_o,
  output logic                 rejected_o
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CW = $clog2(POINTS + 1);

  logic [STAMP_W-1:0] mem [POINTS];
  logic [STAMP_W-1:0] rdata_q;

  logic [CW-1:0]      count_q;
  logic [CW-1:0]      addr_q;
  logic [AW-1:0]      rd_idx_q;
  logic               rd_vld_q;
  logic [KEY_W-1:0]   key_q;
  logic [SEC_W-1:0]   q_sec_q;
  logic [SEC_W-1:0]   prev_sec_q, prev_sec_d;
  logic               matched_q, matched_d;
  logic               stop_q, stop_d;
  logic [MIN_W-1:0]   run_min_q, run_min_d;
  logic [DIST_W-1:0]  best_d_q, best_d_d;
  logic [AW-1:0]      best_i_q, best_i_d;
  logic               have_q, have_d;
  logic               rej_q;

  logic [STAMP_W-1:0] stamp_in;
  logic               do_append;
  logic               do_issue;
  logic               do_eval;
  logic [SEC_W-1:0]   rd_sec;
  logic [MIN_W-1:0]   rd_min;
  logic [DIST_W-1:0]  d_prev, d_run, d_next;

  assign stamp_in  = {year_i, month_i, day_i, hour_i, minute_i, second_i};
  assign do_append = cmd_i.accept && (mode_i == MODE_APPEND) && (count_q < CW'(POINTS));
  assign do_issue  = cmd_i.scan && !stop_q && (addr_q < count_q);
  assign do_eval   = cmd_i.scan && rd_vld_q && !stop_q;

  assign rd_sec = rdata_q[SEC_W-1:0];
  assign rd_min = rdata_q[SEC_W +: MIN_W];

  assign d_prev = abs_diff({1'b0, prev_sec_q}, {1'b0, q_sec_q} + MINUTE_SECONDS);
  assign d_run  = abs_diff({1'b0, rd_sec}, {1'b0, q_sec_q});
  assign d_next = abs_diff({1'b0, rd_sec} + MINUTE_SECONDS, {1'b0, q_sec_q});

  // Single pass over the table: the earlier point's second rides along in
  // prev_sec, so the walk never steps back.
  always_comb begin
    prev_sec_d = prev_sec_q;
    matched_d  = matched_q;
    stop_d     = stop_q;
    run_min_d  = run_min_q;
    best_d_d   = best_d_q;
    best_i_d   = best_i_q;
    have_d     = have_q;
    if (do_eval) begin
      prev_sec_d = rd_sec;
      if (!matched_q) begin
        if (rdata_q[STAMP_W-1:SEC_W] == key_q) begin
          matched_d = 1'b1;
          run_min_d = rd_min;
          if ((rd_idx_q != '0) && (d_prev < best_d_d)) begin
            best_d_d = d_prev;
            best_i_d = rd_idx_q - AW'(1);
            have_d   = 1'b1;
          end
          if (d_run < best_d_d) begin
            best_d_d = d_run;
            best_i_d = rd_idx_q;
            have_d   = 1'b1;
          end
        end
      end else if (rd_min == run_min_q) begin
        if (d_run < best_d_d) begin
          best_d_d = d_run;
          best_i_d = rd_idx_q;
          have_d   = 1'b1;
        end
      end else begin
        // first point past the run closes the search
        stop_d = 1'b1;
        if (d_next < best_d_d) begin
          best_d_d = d_next;
          best_i_d = rd_idx_q;
          have_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      mem[count_q[AW-1:0]] <= stamp_in;
    end
    if (do_issue) begin
      rdata_q <= mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      addr_q    <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      matched_q <= 1'b0;
      stop_q    <= 1'b0;
      run_min_q <= '0;
      best_d_q  <= MINUTE_SECONDS;
      best_i_q  <= '0;
      have_q    <= 1'b0;
      rej_q     <= 1'b0;
      prev_sec_q <= '0;
    end else if (cmd_i.accept) begin
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      matched_q <= 1'b0;
      stop_q    <= 1'b0;
      best_d_q  <= MINUTE_SECONDS;
      best_i_q  <= '0;
      have_q    <= 1'b0;
      rej_q     <= (mode_i == MODE_APPEND) && !do_append;
      if (mode_i == MODE_CLEAR) begin
        count_q <= '0;
      end else if (do_append) begin
        count_q <= count_q + CW'(1);
      end
    end else if (cmd_i.scan) begin
      rd_vld_q   <= do_issue;
      if (do_issue) begin
        rd_idx_q <= addr_q[AW-1:0];
        addr_q   <= addr_q + CW'(1);
      end
      prev_sec_q <= prev_sec_d;
      matched_q  <= matched_d;
      stop_q     <= stop_d;
      run_min_q  <= run_min_d;
      best_d_q   <= best_d_d;
      best_i_q   <= best_i_d;
      have_q     <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q   <= stamp_in[STAMP_W-1:SEC_W];
      q_sec_q <= second_i;
    end
  end

  // Search is over once the run closed or every stored stamp went through.
  assign status_o.done = stop_q || (!rd_vld_q && (addr_q == count_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_o       <= have_q;
      point_index_o <= have_q ? IDX_OUT_W'(best_i_q) : '0;
      rejected_o    <= rej_q;
    end
  end

endmodule

[sv/nearest_track_point_search_unit.sv]
// Clear and append: no table walk; the result loads once the output register is free.
// Query: one stored stamp read per cycle from the stamp memory's single port,
//   from index 0 through the matched minute's run and one point past it.
// One item in flight; the next item is taken the cycle after its result loads.
// Reset empties the table (point count zero); the stamp memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Nearest track point search unit
// Stores track time stamps and finds the point nearest to a query second.
// ----------------------------------------------------------------------------
module nearest_track_point_search_unit
  import ntps_pkg::*;
#(
  parameter int POINTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [YEAR_W-1:0]    year_i,
  input  logic [MONTH_W-1:0]   month_i,
  input  logic [DAY_W-1:0]     day_i,
  input  logic [HOUR_W-1:0]    hour_i,
  input  logic [MIN_W-1:0]     minute_i,
  input  logic [SEC_W-1:0]     second_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [IDX_OUT_W-1:0] point_index_o,
  output logic                 rejected_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ntps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ntps_datapath #(
    .POINTS (POINTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (mode_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .found_o       (found_o),
    .point_index_o (point_index_o),
    .rejected_o    (rejected_o)
  );

  `ASSERT_CLK(a_one_item_in_flight, (in_valid_i && !in_stall_o) |=> in_stall_o, "item accepted while busy")
  `ASSERT_NEVER(a_found_and_rejected, out_valid_o && found_o && rejected_o, "query and append flags both set")
  `ASSERT_CLK(a_index_zero_if_missing, (out_valid_o && !found_o) |-> (point_index_o == '0), "index set without a found point")

endmodule

[tb/sv/tb_nearest_track_point_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest track point search unit testbench
// Runs short directed sequences, then clear/append/query sessions built as
// timed tracks with random content and some noise, and one pass that fills
// the table to capacity. Each accepted item goes to a scoreboard that mirrors
// the stamp table and predicts found, point index and rejected; results are
// compared in order under random idle and stall.
// ----------------------------------------------------------------------------
module tb_nearest_track_point_search_unit;
  import ntps_pkg::*;

  localparam int POINTS = 1024;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Watchdog limit, set with wide margin over the worst real run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] point_index;
    logic                 rejected;
  } result_t;

  class track_scoreboard;
    stamp_t      stamps [POINTS];
    int unsigned n_points;
    result_t     pending_results [$];
    int unsigned mismatches;

    function new();
      n_points   = 0;
      mismatches = 0;
    endfunction

    function int unsigned sec_dist(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function result_t nearest_point(stamp_t s);
      result_t     r;
      int unsigned m, i, d, q, best_d, best_i, run_min;
      bit          have;
      r      = '0;
      q      = s.second;
      best_d = 60;
      best_i = 0;
      have   = 1'b0;
      m      = 0;
      while (m < n_points && stamps[m][STAMP_W-1:SEC_W] != s[STAMP_W-1:SEC_W]) m++;
      if (m < n_points) begin
        run_min = stamps[m].minute;
        // earlier point counts as one minute back
        if (m > 0) begin
          d = sec_dist(stamps[m-1].second, q + 60);
          if (d < best_d) begin
            best_d = d; best_i = m - 1; have = 1'b1;
          end
        end
        i = m;
        while (i < n_points && stamps[i].minute == run_min) begin
          d = sec_dist(stamps[i].second, q);
          if (d < best_d) begin
            best_d = d; best_i = i; have = 1'b1;
          end
          i++;
        end
        // first point past the run counts as one minute ahead
        if (i < n_points) begin
          d = sec_dist(stamps[i].second + 60, q);
          if (d < best_d) begin
            best_d = d; best_i = i; have = 1'b1;
          end
        end
        if (have) begin
          r.found       = 1'b1;
          r.point_index = best_i[IDX_OUT_W-1:0];
        end
      end
      return r;
    endfunction

    function void note_item(logic [1:0] mode, stamp_t s);
      result_t r;
      r = '0;
      case (mode)
        MODE_CLEAR: n_points = 0;
        MODE_APPEND: begin
          if (n_points < POINTS) begin
            stamps[n_points] = s;
            n_points++;
          end else begin
            r.rejected = 1'b1;
          end
        end
        MODE_QUERY: r = nearest_point(s);
        default: r = '0;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic found, logic [IDX_OUT_W-1:0] idx, logic rejected);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result with no item pending");
        return;
      end
      want = pending_results.pop_front();
      if (found !== want.found) begin
        mismatches++;
        $error("found: expected %0d, got %0d", want.found, found);
      end
      if (idx !== want.point_index) begin
        mismatches++;
        $error("point_index: expected %0d, got %0d", want.point_index, idx);
      end
      if (rejected !== want.rejected) begin
        mismatches++;
        $error("rejected: expected %0d, got %0d", want.rejected, rejected);
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           mode_i        = MODE_CLEAR;
  logic [YEAR_W-1:0]    year_i        = '0;
  logic [MONTH_W-1:0]   month_i       = '0;
  logic [DAY_W-1:0]     day_i         = '0;
  logic [HOUR_W-1:0]    hour_i        = '0;
  logic [MIN_W-1:0]     minute_i      = '0;
  logic [SEC_W-1:0]     second_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic                 found_o;
  logic [IDX_OUT_W-1:0] point_index_o;
  logic                 rejected_o;

  track_scoreboard sb;
  stamp_t          stored_q [$];
  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     idle_tab [4] = '{0, 70, 0, 34};
  int unsigned     stall_tab [4] = '{0, 0, 70, 34};

  nearest_track_point_search_unit #(
    .POINTS(POINTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .year_i       (year_i),
    .month_i      (month_i),
    .day_i        (day_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .second_i     (second_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .point_index_o(point_index_o),
    .rejected_o   (rejected_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Receiver side: random stall, check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(found_o, point_index_o, rejected_o);
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic stamp_t at_time(input int unsigned hr, input int unsigned mn,
                                     input int unsigned sc);
    stamp_t s;
    s.year   = 14'd5000;
    s.month  = 4'd6;
    s.day    = 5'd15;
    s.hour   = 5'(hr);
    s.minute = 6'(mn);
    s.second = 6'(sc);
    return s;
  endfunction

  function automatic stamp_t rand_stamp_valid();
    stamp_t s;
    s.year   = 14'($urandom_range(9999));
    s.month  = 4'($urandom_range(1, 12));
    s.day    = 5'($urandom_range(1, 31));
    s.hour   = 5'($urandom_range(23));
    s.minute = 6'($urandom_range(59));
    s.second = 6'($urandom_range(59));
    return s;
  endfunction

  function automatic stamp_t rand_stamp_bits();
    stamp_t s;
    s[31:0]  = $urandom;
    s[39:32] = 8'($urandom);
    return s;
  endfunction

  // Next point along a track: mostly forward in time, sometimes a repeat,
  // a skipped minute or a jump to another hour and minute.
  function automatic stamp_t next_stamp(input stamp_t s);
    stamp_t      nxt;
    int unsigned sec;
    nxt = s;
    case ($urandom_range(9))
      0: begin
        nxt.hour   = 5'($urandom_range(23));
        nxt.minute = 6'($urandom_range(59));
      end
      1: nxt.second = s.second;
      2: nxt.minute = 6'((s.minute + 2) % 60);
      default: begin
        sec = s.second + $urandom_range(1, 45);
        if (sec >= 60) begin
          sec = sec - 60;
          if (nxt.minute >= 59) begin
            nxt.minute = '0;
            nxt.hour   = nxt.hour + 1'b1;
          end else begin
            nxt.minute = nxt.minute + 1'b1;
          end
        end
        nxt.second = sec[SEC_W-1:0];
      end
    endcase
    return nxt;
  endfunction

  function automatic stamp_t query_near(input stamp_t p);
    stamp_t qs;
    qs        = p;
    qs.second = 6'($urandom_range(63));
    if ($urandom_range(9) == 0) qs.minute = p.minute + 1'b1;
    return qs;
  endfunction

  task automatic send_item(input logic [1:0] mode, input stamp_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    year_i     <= s.year;
    month_i    <= s.month;
    day_i      <= s.day;
    hour_i     <= s.hour;
    minute_i   <= s.minute;
    second_i   <= s.second;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(mode, s);
  endtask

  // Hold off until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_session(input int unsigned len, inout int unsigned items);
    stamp_t      cur;
    stamp_t      p;
    int unsigned pick;
    send_item(MODE_CLEAR, rand_stamp_bits());
    stored_q.delete();
    items++;
    cur = rand_stamp_valid();
    repeat (len) begin
      send_item(MODE_APPEND, cur);
      stored_q.push_back(cur);
      cur = next_stamp(cur);
      items++;
    end
    repeat (len / 2 + 3) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        send_item(MODE_UNUSED, rand_stamp_bits());
      end else if (pick == 1) begin
        send_item(MODE_QUERY, rand_stamp_bits());
        items++;
      end else if (pick == 2) begin
        p = rand_stamp_bits();
        send_item(MODE_APPEND, p);
        stored_q.push_back(p);
        items++;
      end else if (pick == 3) begin
        send_item(MODE_APPEND, cur);
        stored_q.push_back(cur);
        cur = next_stamp(cur);
        items++;
      end else begin
        p = stored_q[$urandom_range(stored_q.size() - 1)];
        send_item(MODE_QUERY, query_near(p));
        items++;
      end
    end
  endtask

  task automatic fill_table();
    stamp_t cur;
    stamp_t p;
    send_item(MODE_CLEAR, rand_stamp_bits());
    stored_q.delete();
    cur = rand_stamp_valid();
    repeat (POINTS) begin
      send_item(MODE_APPEND, cur);
      stored_q.push_back(cur);
      cur = next_stamp(cur);
    end
    repeat (3) send_item(MODE_APPEND, rand_stamp_bits());
    // run up to the last entry, then from the first one
    p = stored_q[POINTS-1];
    p.second = 6'($urandom_range(63));
    send_item(MODE_QUERY, p);
    p = stored_q[0];
    p.second = 6'($urandom_range(63));
    send_item(MODE_QUERY, p);
    repeat (12) send_item(MODE_QUERY, query_near(stored_q[$urandom_range(POINTS - 1)]));
    send_item(MODE_CLEAR, rand_stamp_bits());
    send_item(MODE_APPEND, cur);
    send_item(MODE_QUERY, cur);
  endtask

  initial begin
    int unsigned items;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, index zero, ties, run edges, extremes
    send_item(MODE_QUERY,  at_time(10, 20, 30));
    send_item(MODE_APPEND, at_time(10, 20, 30));
    send_item(MODE_QUERY,  at_time(10, 20, 30));
    send_item(MODE_APPEND, at_time(10, 20, 50));
    send_item(MODE_APPEND, at_time(10, 21, 5));
    send_item(MODE_APPEND, at_time(10, 22, 59));
    send_item(MODE_QUERY,  at_time(10, 20, 55));
    send_item(MODE_QUERY,  at_time(10, 20, 40));
    send_item(MODE_QUERY,  at_time(10, 21, 0));
    send_item(MODE_QUERY,  at_time(10, 21, 59));
    send_item(MODE_QUERY,  at_time(10, 22, 0));
    send_item(MODE_QUERY,  at_time(10, 23, 0));
    send_item(MODE_QUERY,  at_time(10, 20, 63));
    // same minute in the next hour still extends the run
    send_item(MODE_APPEND, at_time(11, 22, 10));
    send_item(MODE_QUERY,  at_time(10, 22, 20));
    send_item(MODE_APPEND, '1);
    send_item(MODE_APPEND, '0);
    send_item(MODE_QUERY,  '1);
    send_item(MODE_QUERY,  '0);
    send_item(MODE_UNUSED, '1);
    send_item(MODE_CLEAR,  '0);
    send_item(MODE_QUERY,  at_time(10, 20, 30));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      items     = 0;
      while (items < 100) run_session($urandom_range(1, 48), items);
      drain();
    end

    fill_table();
    drain();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ntps_pkg.sv
sv/ntps_ctrl.sv
sv/ntps_datapath.sv
sv/nearest_track_point_search_unit.sv
tb/sv/tb_nearest_track_point_search_unit.sv
